// File: src/cnms_pkg.sv
// shared constants, types and the direction quantiser for canny non-maximum suppression
package cnms_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAG_BITS_DEFAULT  = 16;

   localparam int ANGLE_BITS    = 11;
   localparam int FW_BITS       = 11;
   localparam int FH_BITS       = 12;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 12;
   // wide enough for frame_height + 1 and for any width up to 4096
   localparam int GEOM_BITS     = 13;
   localparam int MIN_DIM       = 3;

   localparam logic signed [ANGLE_BITS:0] ANG_HALF = 720;
   localparam logic signed [ANGLE_BITS:0] ANG_FULL = 1440;
   localparam logic signed [ANGLE_BITS:0] BOUND_A  = 90;
   localparam logic signed [ANGLE_BITS:0] BOUND_B  = 270;
   localparam logic signed [ANGLE_BITS:0] BOUND_C  = 450;
   localparam logic signed [ANGLE_BITS:0] BOUND_D  = 630;

   typedef enum logic [1:0] {
      SECT_HORIZ,
      SECT_DIAG_UP,
      SECT_DIAG_DOWN,
      SECT_VERT
   } sector_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic emit_border;
      logic last;
      logic emit_interior;
      logic suppress;
   } stage_ctl_type;

   // quarter degrees folded to -719..720, then split into four sectors
   function automatic sector_type quantize(input logic [ANGLE_BITS-1:0] raw);
      logic signed [ANGLE_BITS:0] a;
      sector_type s;
      a = $signed({1'b0, raw});
      if (a > ANG_HALF) begin
         a = a - ANG_FULL;
      end
      if ((a <= BOUND_A && a > -BOUND_A) || a > BOUND_D || a <= -BOUND_D) begin
         s = SECT_HORIZ;
      end else if ((a > BOUND_A && a <= BOUND_B) || (a > -BOUND_D && a <= -BOUND_C)) begin
         s = SECT_DIAG_UP;
      end else if ((a > BOUND_C && a <= BOUND_D) || (a > -BOUND_B && a <= -BOUND_A)) begin
         s = SECT_DIAG_DOWN;
      end else begin
         s = SECT_VERT;
      end
      return s;
   endfunction

endpackage

// File: src/cnms_req_if.sv
// pixel input channel: magnitude, angle and flush marker
interface cnms_req_if #(
   parameter int MAG_BITS = cnms_pkg::MAG_BITS_DEFAULT
);
   logic                            valid;
   logic                            ready;
   logic [MAG_BITS-1:0]             pixel_magnitude;
   logic [cnms_pkg::ANGLE_BITS-1:0] pixel_angle;
   logic                            flush;

   modport source (output valid, output pixel_magnitude, output pixel_angle, output flush,
                   input ready);
   modport sink   (input valid, input pixel_magnitude, input pixel_angle, input flush,
                   output ready);
endinterface

// File: src/cnms_rsp_if.sv
// result channel: suppressed magnitude and end-of-frame marker
interface cnms_rsp_if #(
   parameter int MAG_BITS = cnms_pkg::MAG_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic [MAG_BITS-1:0] out_magnitude;
   logic                last_pixel;

   modport source (output valid, output out_magnitude, output last_pixel, input ready);
   modport sink   (input valid, input out_magnitude, input last_pixel, output ready);
endinterface

// File: src/cnms_csr_if.sv
// register write channel: register index and write data
interface cnms_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cnms_pkg::CSR_IDX_BITS-1:0]  index;
   logic [cnms_pkg::CSR_DATA_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/canny_nonmax_suppression_top.sv
// canny non-maximum suppression, 3x3 window, one pixel per clock unless stalled
//
// req_ch takes pixels in raster order (magnitude, angle, flush). rsp_ch gives
// one suppressed magnitude per pixel, lagging the input stream by one row
// plus one pixel; last_pixel marks the frame's final result. After the last
// real pixel, flush transfers (width + 1 of them) drain the tail; a flush
// inside the frame is taken and dropped.
// csr_ch writes frame_width and frame_height; it is always ready. The user must
// see that it is only written while the block is idle; no logic checks this.
// An item enters the input stage at its transfer, its line-store read comes
// back in the same register stage, and its result enters the output register
// as it advances. Unless rsp_ch stalls, one item per cycle is sustained; the
// rate is set by the single line-store port pair (one read, one write a cycle).
// When rsp_ch stalls the output register holds, the input stage holds its
// item if that item has a result, and req_ch.ready falls only then.
// Reset clears position, window, channels and registers to 640 x 480; the line
// stores are not cleared, since every entry is written before it is used.
module canny_nonmax_suppression_top #(
   parameter int MAX_WIDTH = cnms_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAG_BITS  = cnms_pkg::MAG_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   cnms_req_if.sink    req_ch,
   cnms_rsp_if.source  rsp_ch,
   cnms_csr_if.sink    csr_ch
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int GB        = cnms_pkg::GEOM_BITS;
   localparam int WORD_BITS = 2 * MAG_BITS + 2;
   localparam logic [GB-1:0] MAX_W = GB'(MAX_WIDTH);
   localparam logic [GB-1:0] MIN_D = GB'(cnms_pkg::MIN_DIM);
   localparam logic [GB-1:0] ONE   = GB'(1);
   localparam logic [GB-1:0] TWO   = GB'(2);

   // configuration
   logic [cnms_pkg::FW_BITS-1:0] frame_width_ff;
   logic [cnms_pkg::FH_BITS-1:0] frame_height_ff;

   // position of the next item
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [GB-1:0]       row_ff, row_in;

   // input stage
   logic                    s1_valid_ff;
   cnms_pkg::stage_ctl_type s1_ctl_ff;
   logic [COL_BITS-1:0]     s1_addr_ff;
   logic [MAG_BITS-1:0]     s1_mag_ff;
   cnms_pkg::sector_type    s1_sect_ff;
   logic [WORD_BITS-1:0]    rd_ff;
   logic                    byp_ff;
   logic [WORD_BITS-1:0]    byp_data_ff;

   // line stores: {row above, current row, sector}
   logic [WORD_BITS-1:0] line_mem [MAX_WIDTH];

   logic [MAG_BITS-1:0]  win_ff [3][3];
   logic [MAG_BITS-1:0]  win_in [3][3];
   cnms_pkg::sector_type held_sect_ff;

   logic                rsp_valid_ff;
   logic [MAG_BITS-1:0] rsp_mag_ff;
   logic                rsp_last_ff;

   // accept-side decode
   logic [GB-1:0]           w, h, h_end, fw, fh, col_x, row_x, col_inc;
   logic                    acc_drain, acc_ignore, accept, enter;
   cnms_pkg::stage_ctl_type acc_ctl;
   logic [COL_BITS-1:0]     acc_addr;

   // stage-side decode
   logic [WORD_BITS-1:0] rd_word, wr_data;
   logic [MAG_BITS-1:0]  top_rd, mid_rd, cur, na, nb, interior_val, rsp_mag_in;
   cnms_pkg::sector_type sect_rd;
   logic                 s1_has_rsp, out_free, advance;

   always_comb begin
      fw = GB'(frame_width_ff);
      fh = GB'(frame_height_ff);
      if (fw < MIN_D) begin
         w = MIN_D;
      end else if (fw > MAX_W) begin
         w = MAX_W;
      end else begin
         w = fw;
      end
      h     = (fh < MIN_D) ? MIN_D : fh;
      h_end = h + ONE;

      // pull the position back inside the current geometry
      col_x = GB'(col_ff);
      row_x = row_ff;
      if (col_x >= w) begin
         col_x = '0;
         row_x = row_ff + ONE;
      end
      if (row_x > h_end) begin
         row_x = h_end;
         col_x = '0;
      end
      if (row_x == h_end) begin
         col_x = '0;
      end

      acc_drain  = (row_x >= h);
      acc_ignore = req_ch.flush && !acc_drain;

      acc_ctl.emit_border   = (col_x == '0) && (row_x >= TWO);
      acc_ctl.last          = acc_ctl.emit_border && (row_x == h_end);
      acc_ctl.emit_interior = (col_x != '0) && (row_x != '0);
      acc_ctl.suppress      = (col_x >= TWO) && (row_x >= TWO) && (row_x <= h - ONE);
      acc_addr              = col_x[COL_BITS-1:0];

      col_inc = col_x + ONE;
      if (acc_ctl.last) begin
         col_in = '0;
         row_in = '0;
      end else if (col_inc >= w) begin
         col_in = '0;
         row_in = row_x + ONE;
      end else begin
         col_in = col_inc[COL_BITS-1:0];
         row_in = row_x;
      end
   end

   assign accept = req_ch.valid && req_ch.ready;
   assign enter  = accept && !acc_ignore;

   always_comb begin
      rd_word = byp_ff ? byp_data_ff : rd_ff;
      top_rd  = rd_word[WORD_BITS-1 -: MAG_BITS];
      mid_rd  = rd_word[MAG_BITS+1 -: MAG_BITS];
      sect_rd = cnms_pkg::sector_type'(rd_word[1:0]);

      s1_has_rsp = s1_ctl_ff.emit_border || s1_ctl_ff.emit_interior;
      out_free   = !rsp_valid_ff || rsp_ch.ready;
      advance    = s1_valid_ff && (!s1_has_rsp || out_free);

      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = top_rd;
      win_in[1][2] = mid_rd;
      win_in[2][2] = s1_mag_ff;

      cur = win_in[1][1];
      unique case (held_sect_ff)
         cnms_pkg::SECT_HORIZ: begin
            na = win_in[1][2];
            nb = win_in[1][0];
         end
         cnms_pkg::SECT_DIAG_UP: begin
            na = win_in[2][0];
            nb = win_in[0][2];
         end
         cnms_pkg::SECT_DIAG_DOWN: begin
            na = win_in[0][0];
            nb = win_in[2][2];
         end
         default: begin
            na = win_in[2][1];
            nb = win_in[0][1];
         end
      endcase

      if (s1_ctl_ff.suppress && (cur < na || cur < nb)) begin
         interior_val = '0;
      end else begin
         interior_val = cur;
      end
      // column 0 gives the right border pixel of the row two back
      rsp_mag_in = s1_ctl_ff.emit_border ? win_ff[1][2] : interior_val;

      wr_data = {mid_rd, s1_mag_ff, s1_sect_ff};
   end

   assign req_ch.ready         = !s1_valid_ff || advance;
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_magnitude = rsp_mag_ff;
   assign rsp_ch.last_pixel    = rsp_last_ff;

   // line store, one write and one read a cycle
   always_ff @(posedge clock) begin
      if (advance) begin
         line_mem[s1_addr_ff] <= wr_data;
      end
      if (enter) begin
         rd_ff       <= line_mem[acc_addr];
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (enter) begin
         s1_ctl_ff  <= acc_ctl;
         s1_addr_ff <= acc_addr;
         s1_mag_ff  <= acc_drain ? '0 : req_ch.pixel_magnitude;
         s1_sect_ff <= acc_drain ? cnms_pkg::SECT_HORIZ
                                 : cnms_pkg::quantize(req_ch.pixel_angle);
      end
      if (advance && s1_has_rsp) begin
         rsp_mag_ff  <= rsp_mag_in;
         rsp_last_ff <= s1_ctl_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= cnms_pkg::FW_BITS'(640);
         frame_height_ff <= cnms_pkg::FH_BITS'(480);
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         byp_ff          <= 1'b0;
         held_sect_ff    <= cnms_pkg::SECT_HORIZ;
         rsp_valid_ff    <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (cnms_pkg::csr_index_type'(csr_ch.index))
               cnms_pkg::CSR_FRAME_WIDTH: begin
                  frame_width_ff <= csr_ch.data[cnms_pkg::FW_BITS-1:0];
               end
               cnms_pkg::CSR_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_ch.data[cnms_pkg::FH_BITS-1:0];
               end
               default: begin
               end
            endcase
         end

         if (enter) begin
            col_ff <= col_in;
            row_ff <= row_in;
            // same column written by the leaving item: forward its data
            byp_ff <= advance && (s1_addr_ff == acc_addr);
         end else if (accept) begin
            // a dropped flush still keeps the pulled-back position
            col_ff <= col_x[COL_BITS-1:0];
            row_ff <= row_x;
         end

         if (enter) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end

         if (advance) begin
            win_ff       <= win_in;
            held_sect_ff <= sect_rd;
         end

         if (advance && s1_has_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   // a frame-ending item restarts the position at the top left
   assert property (@(posedge clock) disable iff (reset)
      enter && acc_ctl.last |=> row_ff == '0 && col_ff == '0)
      else $error("position not restarted after last pixel");

   // a stalled stage item keeps its place and its column
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_addr_ff))
      else $error("stage item lost while stalled");

   // forwarding only follows a line-store write
   assert property (@(posedge clock) disable iff (reset)
      $rose(byp_ff) |-> $past(advance))
      else $error("forwarding without a write");

   // a result never overwrites one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(rsp_mag_ff))
      else $error("waiting result overwritten");
`endif

endmodule

// File: tb/sv/tb_canny_nonmax_suppression_top.sv
// self-checking testbench for the canny non-maximum suppression block
module tb_canny_nonmax_suppression_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W       = 1024;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 10;

   // sector boundaries in quarter degrees, and the fold of the angle range
   localparam int ANG_22_5  = 90;
   localparam int ANG_67_5  = 270;
   localparam int ANG_112_5 = 450;
   localparam int ANG_157_5 = 630;
   localparam int ANG_180   = 720;
   localparam int ANG_360   = 1440;

   // raw angles that sit on a sector edge, both sides of the fold and above 1439
   localparam int ANGLE_EDGES [11] = '{90, 270, 450, 630, 810, 990, 1170, 1350,
                                       1530, 1710, 1890};

   typedef struct packed {
      logic [15:0] magnitude;
      logic        last;
   } pixel_result_type;

   typedef enum logic [1:0] {
      RESULT_NONE,
      RESULT_PREDICTED,
      RESULT_LISTED
   } result_source_type;

   typedef struct packed {
      logic [15:0]       magnitude;
      logic [10:0]       angle;
      logic              flush;
      result_source_type source;
      logic [15:0]       exp_magnitude;
      logic              exp_last;
   } directed_row_type;

   // one 3x3 frame: border results typed in, the centre left to the predictor
   localparam directed_row_type DIRECTED [14] = '{
      '{16'h0000, 11'd0,    1'b0, RESULT_NONE,      16'h0000, 1'b0},
      '{16'hFFFF, 11'd1439, 1'b0, RESULT_NONE,      16'h0000, 1'b0},
      '{16'hAAAA, 11'h555,  1'b1, RESULT_NONE,      16'h0000, 1'b0}, // flush inside frame
      '{16'h1234, 11'd2047, 1'b0, RESULT_NONE,      16'h0000, 1'b0},
      '{16'h0100, 11'd90,   1'b0, RESULT_NONE,      16'h0000, 1'b0},
      '{16'h0800, 11'd360,  1'b0, RESULT_LISTED,    16'h0000, 1'b0},
      '{16'h00FF, 11'd720,  1'b0, RESULT_LISTED,    16'hFFFF, 1'b0},
      '{16'hFFFF, 11'd721,  1'b0, RESULT_LISTED,    16'h1234, 1'b0},
      '{16'h0001, 11'd1440, 1'b0, RESULT_LISTED,    16'h0100, 1'b0},
      '{16'h8000, 11'd630,  1'b0, RESULT_PREDICTED, 16'h0000, 1'b0},
      '{16'h0000, 11'd0,    1'b1, RESULT_LISTED,    16'h00FF, 1'b0},
      '{16'h5555, 11'h2AA,  1'b0, RESULT_LISTED,    16'hFFFF, 1'b0}, // pixel in the drain
      '{16'h0000, 11'd0,    1'b1, RESULT_LISTED,    16'h0001, 1'b0},
      '{16'h0000, 11'd0,    1'b1, RESULT_LISTED,    16'h8000, 1'b1}
   };

   logic clock;
   logic reset;

   cnms_req_if req_ch ();
   cnms_rsp_if rsp_ch ();
   cnms_csr_if csr_ch ();

   canny_nonmax_suppression_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   logic [10:0]          frame_w_reg;
   logic [11:0]          frame_h_reg;
   logic [15:0]          mag_rows [2][MAX_W];
   cnms_pkg::sector_type sector_row [MAX_W];
   logic [15:0]          win3 [3][3];
   int                   col_pos;
   int                   row_pos;
   cnms_pkg::sector_type held_sector_q;

   pixel_result_type expected_results [$];
   int               fault_count;
   int               pixel_count;
   int               send_idle_pct;
   int               recv_idle_pct;
   logic             pressure_armed;
   int               cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_width(input logic [10:0] raw);
      int w;
      w = int'(raw);
      if (w < 3) w = 3;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int clamp_height(input logic [11:0] raw);
      int h;
      h = int'(raw);
      if (h < 3) h = 3;
      return h;
   endfunction

   function automatic cnms_pkg::sector_type angle_sector(input logic [10:0] raw);
      int a;
      a = int'(raw);
      if (a > ANG_180) a = a - ANG_360;
      if ((a <= ANG_22_5 && a > -ANG_22_5) || a > ANG_157_5 || a <= -ANG_157_5)
         return cnms_pkg::SECT_HORIZ;
      if ((a > ANG_22_5 && a <= ANG_67_5) || (a > -ANG_157_5 && a <= -ANG_112_5))
         return cnms_pkg::SECT_DIAG_UP;
      if ((a > ANG_112_5 && a <= ANG_157_5) || (a > -ANG_67_5 && a <= -ANG_22_5))
         return cnms_pkg::SECT_DIAG_DOWN;
      return cnms_pkg::SECT_VERT;
   endfunction

   // advances the window by one transfer; returns 1 when a result is due
   function automatic bit predict_pixel(input logic [15:0] mag, input logic [10:0] ang,
                                        input logic flush, output pixel_result_type res);
      int                   w, h, c, r, col;
      bit                   draining, emitted, last;
      logic [15:0]          m, top, mid, cur, na, nb;
      cnms_pkg::sector_type s, centre;
      w = clamp_width(frame_w_reg);
      h = clamp_height(frame_h_reg);
      res = '0;
      emitted = 1'b0;
      last = 1'b0;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos > h + 1) begin
         row_pos = h + 1;
         col_pos = 0;
      end
      if (row_pos == h + 1) col_pos = 0;
      draining = row_pos >= h;
      if (flush && !draining) return 1'b0;
      m = draining ? 16'h0000 : mag;
      s = draining ? cnms_pkg::SECT_HORIZ : angle_sector(ang);
      c = col_pos;

      // start of a row: right border pixel of the row two back
      if (c == 0 && row_pos >= 2) begin
         last = (row_pos - 2 == h - 1);
         res = '{win3[1][2], last};
         emitted = 1'b1;
      end

      top = mag_rows[0][c];
      mid = mag_rows[1][c];
      for (int k = 0; k < 3; k++) begin
         win3[k][0] = win3[k][1];
         win3[k][1] = win3[k][2];
      end
      win3[0][2] = top;
      win3[1][2] = mid;
      win3[2][2] = m;
      mag_rows[0][c] = mid;
      mag_rows[1][c] = m;

      centre = held_sector_q;
      held_sector_q = sector_row[c];
      sector_row[c] = s;

      if (c >= 1 && row_pos >= 1) begin
         r = row_pos - 1;
         col = c - 1;
         cur = win3[1][1];
         if (r >= 1 && r <= h - 2 && col >= 1) begin
            case (centre)
               cnms_pkg::SECT_HORIZ: begin
                  na = win3[1][2];
                  nb = win3[1][0];
               end
               cnms_pkg::SECT_DIAG_UP: begin
                  na = win3[2][0];
                  nb = win3[0][2];
               end
               cnms_pkg::SECT_DIAG_DOWN: begin
                  na = win3[0][0];
                  nb = win3[2][2];
               end
               default: begin
                  na = win3[2][1];
                  nb = win3[0][1];
               end
            endcase
            if (cur < na || cur < nb) cur = 16'h0000;
         end
         res = '{cur, 1'b0};
         emitted = 1'b1;
      end

      if (last) begin
         row_pos = 0;
         col_pos = 0;
      end else begin
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
      end
      return emitted;
   endfunction

   function automatic logic [15:0] random_magnitude();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [10:0] random_angle();
      if ($urandom_range(0, 1))
         return 11'(ANGLE_EDGES[$urandom_range(0, 10)] + $urandom_range(0, 2) - 1);
      return 11'($urandom_range(0, 2047));
   endfunction

   task automatic send_item(input logic [15:0] mag, input logic [10:0] ang,
                            input logic flush, output bit emitted,
                            output pixel_result_type res);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.pixel_magnitude <= mag;
      req_ch.pixel_angle     <= ang;
      req_ch.flush           <= flush;
      do @(posedge clock); while (!req_ch.ready);
      emitted = predict_pixel(mag, ang, flush, res);
   endtask

   task automatic send_checked(input logic [15:0] mag, input logic [10:0] ang,
                               input logic flush);
      bit               emitted;
      pixel_result_type res;
      send_item(mag, ang, flush, emitted, res);
      if (emitted) expected_results.push_back(res);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_geometry(input logic [11:0] raw_w, input logic [11:0] raw_h);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= cnms_pkg::CSR_FRAME_WIDTH;
      csr_ch.data  <= raw_w;
      do @(posedge clock); while (!csr_ch.ready);
      frame_w_reg = raw_w[10:0];
      csr_ch.index <= cnms_pkg::CSR_FRAME_HEIGHT;
      csr_ch.data  <= raw_h;
      do @(posedge clock); while (!csr_ch.ready);
      frame_h_reg = raw_h;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_frames(input logic [11:0] raw_w, input logic [11:0] raw_h,
                             input int frames);
      int w, h;
      wait_idle();
      write_geometry(raw_w, raw_h);
      w = clamp_width(raw_w[10:0]);
      h = clamp_height(raw_h);
      repeat (frames) begin
         for (int i = 0; i < w * h; i++) begin
            // stray flush inside the frame, dropped by the block
            if ($urandom_range(0, 99) < 4)
               send_checked(random_magnitude(), random_angle(), 1'b1);
            send_checked(random_magnitude(), random_angle(), 1'b0);
            pixel_count++;
         end
         // drain: flushes, or pixels that count as flushes
         for (int i = 0; i <= w; i++)
            send_checked(random_magnitude(), random_angle(), $urandom_range(0, 99) < 70);
      end
   endtask

   task automatic run_random_frames(input int quota);
      int          start;
      logic [11:0] raw_w, raw_h;
      start = pixel_count;
      while (pixel_count - start < quota) begin
         raw_w = 12'(($urandom_range(0, 99) < 10) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 20));
         // bit 11 of the width write is masked off
         if ($urandom_range(0, 1)) raw_w[11] = 1'b1;
         raw_h = 12'(($urandom_range(0, 99) < 10) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 7));
         run_frames(raw_w, raw_h, $urandom_range(1, 3));
      end
   endtask

   // result side: random stalls plus one long hold-off
   initial begin
      pixel_result_type want;
      int               hold_left;
      bit               pressure_done;
      hold_left = 0;
      pressure_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("unexpected result: magnitude %h last %b",
                           rsp_ch.out_magnitude, rsp_ch.last_pixel);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.out_magnitude !== want.magnitude ||
                   rsp_ch.last_pixel !== want.last) begin
                  fault_count++;
                  if (fault_count <= MAX_REPORTS)
                     $display("mismatch: expected magnitude %h last %b, %s %h last %b",
                              want.magnitude, want.last, "got magnitude",
                              rsp_ch.out_magnitude, rsp_ch.last_pixel);
               end
            end
         end
         // hold-off starts once the sender is offering items
         if (pressure_armed && !pressure_done && req_ch.valid) begin
            hold_left = HOLD_CYCLES;
            pressure_done = 1'b1;
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      bit               emitted;
      pixel_result_type res;
      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.pixel_magnitude <= '0;
      req_ch.pixel_angle     <= '0;
      req_ch.flush           <= 1'b0;
      csr_ch.valid           <= 1'b0;
      csr_ch.index           <= cnms_pkg::CSR_FRAME_WIDTH;
      csr_ch.data            <= '0;
      pressure_armed         <= 1'b0;
      fault_count   = 0;
      pixel_count   = 0;
      send_idle_pct = 28;
      recv_idle_pct = 86;
      frame_w_reg   = 11'd640;
      frame_h_reg   = 12'd480;
      col_pos       = 0;
      row_pos       = 0;
      held_sector_q = cnms_pkg::SECT_HORIZ;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            win3[i][j] = 16'h0000;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_geometry(12'd3, 12'd3);
      for (int i = 0; i < $size(DIRECTED); i++) begin
         send_item(DIRECTED[i].magnitude, DIRECTED[i].angle, DIRECTED[i].flush, emitted, res);
         case (DIRECTED[i].source)
            RESULT_LISTED:
               expected_results.push_back(pixel_result_type'{DIRECTED[i].exp_magnitude,
                                                             DIRECTED[i].exp_last});
            RESULT_PREDICTED:
               if (emitted) expected_results.push_back(res);
            default: ;
         endcase
      end

      run_frames(12'd3, 12'd3, 2);
      run_random_frames(230);

      send_idle_pct = 86;
      recv_idle_pct = 28;
      run_frames(12'd40, 12'd2, 1); // wide row, height clamped
      run_random_frames(230);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      pressure_armed <= 1'b1;
      run_frames(12'd3, 12'd40, 1); // tall frame
      run_random_frames(230);

      wait_idle();
      if (expected_results.size() != 0) fault_count++;
      if (fault_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
